### rtl/core/pid_controller_assert.svh
// assertion macros shared by the pid controller rtl
// depends on nothing; the including module must provide i_clk and i_rst_n
`ifndef PID_CONTROLLER_ASSERT_SVH
`define PID_CONTROLLER_ASSERT_SVH

// implication checked every cycle outside reset
`define PID_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pid assertion failed");

// next-cycle implication checked outside reset
`define PID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pid assertion failed");

// next-cycle implication that also holds across reset
`define PID_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("pid assertion failed");

`endif

### rtl/core/pid_pkg.sv
// types and constants for the pid controller
// depends on nothing
package pid_pkg;

    localparam int ERR_W     = 16;
    localparam int GAIN_W    = 24;
    localparam int SUM_W     = 32;
    localparam int GAIN_FRAC = 20;
    localparam int DIFF_W    = ERR_W + 1;

    localparam int PROD_P_W  = GAIN_W + ERR_W;
    localparam int PROD_D_W  = GAIN_W + DIFF_W;
    localparam int PROD_I_W  = GAIN_W + SUM_W;
    localparam int ACC_W     = PROD_I_W + 2;
    localparam int SHIFT_W   = ACC_W - GAIN_FRAC;

    // -x + 2^(frac-1) == ~x + 2^(frac-1) + 1
    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'((64'd1 << (GAIN_FRAC - 1)) + 64'd1);

    localparam logic signed [ERR_W-1:0] DRIVE_MAX = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] DRIVE_MIN = {1'b1, {(ERR_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

    localparam int WORK_DEPTH = 4;
    localparam int WORK_PTR_W = $clog2(WORK_DEPTH);
    localparam int WORK_CNT_W = $clog2(WORK_DEPTH + 1);
    localparam int RES_DEPTH  = 4;
    localparam int RES_PTR_W  = $clog2(RES_DEPTH);
    localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 2'd2;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
    } t_gains;

    typedef struct packed {
        logic signed [ERR_W-1:0]  error_sample;
        logic signed [DIFF_W-1:0] deriv;
        logic signed [SUM_W-1:0]  integ;
        logic                     sum_clipped;
    } t_work;

    typedef struct packed {
        logic signed [ERR_W-1:0] drive;
        logic                    drive_clipped;
        logic                    sum_clipped;
    } t_result;

endpackage

### rtl/core/pid_front.sv
// front end: accepts error words, updates history and integral, queues work
// depends on pid_pkg
module pid_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [pid_pkg::ERR_W-1:0] i_error_sample,
    input  logic                          i_restart,
    output logic                          o_work_valid,
    input  logic                          i_work_ready,
    output pid_pkg::t_work                o_work
);
    import pid_pkg::*;

    logic signed [ERR_W-1:0]  r_last_error, n_last_error;
    logic signed [SUM_W-1:0]  r_error_sum, n_error_sum;
    t_work                    r_work_q [WORK_DEPTH];
    logic [WORK_PTR_W-1:0]    r_wr_ptr, r_rd_ptr;
    logic [WORK_CNT_W-1:0]    r_count;

    logic                     accept, take;
    logic signed [ERR_W-1:0]  base_last;
    logic signed [SUM_W-1:0]  base_sum;
    logic signed [SUM_W:0]    sum_wide;
    t_work                    new_work;

    assign full         = (r_count == WORK_CNT_W'(WORK_DEPTH));
    assign accept       = push && !full;
    assign o_work_valid = (r_count != '0);
    assign take         = o_work_valid && i_work_ready;
    assign o_work       = r_work_q[r_rd_ptr];

    always_comb begin
        base_last = i_restart ? '0 : r_last_error;
        base_sum  = i_restart ? '0 : r_error_sum;
        sum_wide  = (SUM_W+1)'(base_sum) + (SUM_W+1)'(i_error_sample);
        new_work.error_sample = i_error_sample;
        new_work.deriv        = DIFF_W'(i_error_sample) - DIFF_W'(base_last);
        new_work.sum_clipped  = (sum_wide[SUM_W] != sum_wide[SUM_W-1]);
        if (!new_work.sum_clipped) begin
            new_work.integ = sum_wide[SUM_W-1:0];
        end else if (sum_wide[SUM_W]) begin
            new_work.integ = SUM_MIN;
        end else begin
            new_work.integ = SUM_MAX;
        end
        n_last_error = accept ? i_error_sample : r_last_error;
        n_error_sum  = accept ? new_work.integ : r_error_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
            r_error_sum  <= '0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            r_last_error <= n_last_error;
            r_error_sum  <= n_error_sum;
            if (accept) begin
                r_wr_ptr <= (r_wr_ptr == WORK_PTR_W'(WORK_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (take) begin
                r_rd_ptr <= (r_rd_ptr == WORK_PTR_W'(WORK_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (accept && !take) begin
                r_count <= r_count + 1'b1;
            end else if (take && !accept) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_work_q[r_wr_ptr] <= new_work;
        end
    end

endmodule

### rtl/core/pid_back.sv
// back end: gain multiply, sum, round and clamp, then the result queue
// depends on pid_pkg
module pid_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pid_pkg::t_gains           i_gains,
    input  logic                      i_work_valid,
    output logic                      o_work_ready,
    input  pid_pkg::t_work            i_work,
    output logic                      empty,
    input  logic                      pop,
    output pid_pkg::t_result          o_result
);
    import pid_pkg::*;

    // stage 1: products
    logic                        r_v1;
    logic signed [PROD_P_W-1:0]  r_prod_p;
    logic signed [PROD_D_W-1:0]  r_prod_d;
    logic signed [PROD_I_W-1:0]  r_prod_i;
    logic                        r_sclip1;
    // stage 2: weighted sum
    logic                        r_v2;
    logic signed [ACC_W-1:0]     r_sum;
    logic                        r_sclip2;
    // result queue
    t_result                     r_res_q [RES_DEPTH];
    logic [RES_PTR_W-1:0]        r_wr_ptr, r_rd_ptr;
    logic [RES_CNT_W-1:0]        r_count;

    logic                        take, res_pop;
    logic [RES_CNT_W:0]          pending;
    logic signed [ACC_W-1:0]     acc;
    logic signed [SHIFT_W-1:0]   shifted;
    logic [SHIFT_W-ERR_W:0]      upper;
    t_result                     new_res;

    // room for everything in flight keeps the pipeline free of stalls
    assign pending      = (RES_CNT_W+1)'(r_count) + (RES_CNT_W+1)'(r_v1)
                          + (RES_CNT_W+1)'(r_v2);
    assign o_work_ready = (pending < (RES_CNT_W+1)'(RES_DEPTH));
    assign take         = i_work_valid && o_work_ready;
    assign empty        = (r_count == '0);
    assign res_pop      = pop && !empty;
    assign o_result     = r_res_q[r_rd_ptr];

    always_comb begin
        acc     = ~r_sum + ROUND_BIAS;
        shifted = acc[ACC_W-1:GAIN_FRAC];
        upper   = shifted[SHIFT_W-1:ERR_W-1];
        new_res.sum_clipped = r_sclip2;
        if ((upper == '0) || (upper == '1)) begin
            new_res.drive         = shifted[ERR_W-1:0];
            new_res.drive_clipped = 1'b0;
        end else begin
            new_res.drive         = shifted[SHIFT_W-1] ? DRIVE_MIN : DRIVE_MAX;
            new_res.drive_clipped = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_p <= i_gains.prop_gain * i_work.error_sample;
        r_prod_d <= i_gains.deriv_gain * i_work.deriv;
        r_prod_i <= i_gains.integ_gain * i_work.integ;
        r_sclip1 <= i_work.sum_clipped;
        r_sum    <= ACC_W'(r_prod_p) + ACC_W'(r_prod_d) + ACC_W'(r_prod_i);
        r_sclip2 <= r_sclip1;
        if (r_v2) begin
            r_res_q[r_wr_ptr] <= new_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_v1 <= take;
            r_v2 <= r_v1;
            if (r_v2) begin
                r_wr_ptr <= (r_wr_ptr == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (res_pop) begin
                r_rd_ptr <= (r_rd_ptr == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (r_v2 && !res_pop) begin
                r_count <= r_count + 1'b1;
            end else if (res_pop && !r_v2) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/pid_controller.sv
// pid controller top: gain registers, front end, back end
// a pushed word passes the work queue, product and sum registers and result queue
// throughput: one word per cycle while results are popped, else full holds the input
// reset: synchronous active-low; clears gains, history, integral and both queues
// depends on pid_pkg, pid_front, pid_back and pid_controller_assert.svh
`include "pid_controller_assert.svh"

module pid_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // error word input
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [pid_pkg::ERR_W-1:0]     i_error_sample,
    input  logic                                 i_restart,
    // result word output
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [pid_pkg::ERR_W-1:0]     o_drive,
    output logic                                 o_drive_clipped,
    output logic                                 o_sum_clipped,
    // gain register writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pid_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pid_pkg::GAIN_W-1:0]           i_cfg_data
);
    import pid_pkg::*;

    t_gains   r_gains, n_gains;
    logic     cfg_write;
    logic     work_valid, work_ready;
    t_work    work;
    t_result  result;

    // gains always writable; user writes only while the block is idle, not enforced
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    // register decode, unknown index leaves all gains unchanged
    always_comb begin
        n_gains = r_gains;
        if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:  n_gains.prop_gain  = i_cfg_data;
                CFG_INTEG_GAIN: n_gains.integ_gain = i_cfg_data;
                CFG_DERIV_GAIN: n_gains.deriv_gain = i_cfg_data;
                default:        n_gains = r_gains;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= '0;
        end else begin
            r_gains <= n_gains;
        end
    end

    // front: restart handling, derivative, saturating integral, work queue
    pid_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_error_sample (i_error_sample),
        .i_restart      (i_restart),
        .o_work_valid   (work_valid),
        .i_work_ready   (work_ready),
        .o_work         (work)
    );

    // back: three gain products, negated sum, rounding, drive clamp
    pid_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gains      (r_gains),
        .i_work_valid (work_valid),
        .o_work_ready (work_ready),
        .i_work       (work),
        .empty        (empty),
        .pop          (pop),
        .o_result     (result)
    );

    assign o_drive         = result.drive;
    assign o_drive_clipped = result.drive_clipped;
    assign o_sum_clipped   = result.sum_clipped;

    // a clipped drive sits exactly on one of the rails
    `PID_ASSERT_IMPL(a_clip_on_rail, !empty && o_drive_clipped,
        (o_drive == DRIVE_MAX) || (o_drive == DRIVE_MIN))
    // a proportional gain write lands in the next cycle
    `PID_ASSERT_NEXT(a_prop_write, cfg_write && (i_cfg_index == CFG_PROP_GAIN),
        r_gains.prop_gain == $past(i_cfg_data))
    // reset leaves both queues empty
    `PID_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, empty && !full)

endmodule

### verif/pid_controller_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for pid_controller: queue-style sample and result ports plus gain writes
// depends on pid_pkg and the pid_controller rtl; predicts every drive word in plain integer math

module pid_controller_tb;

    import pid_pkg::*;

    localparam int CYCLE_LIMIT = 60000;
    localparam int DRAIN_LIMIT = 20000;
    localparam int LAT_CYCLES  = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int SAT_WORDS   = 100;

    // index past the last gain register, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
    localparam logic [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
    localparam logic [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << GAIN_FRAC);
    localparam logic [GAIN_W-1:0] GAIN_HALF = GAIN_W'(1 << (GAIN_FRAC - 1));
    localparam longint ROUND_HALF = 64'sd1 << (GAIN_FRAC - 1);

    typedef struct {
        logic signed [ERR_W-1:0] error_sample;
        logic                    restart;
    } t_err_word;

    // dut ports, inputs all known from time zero
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    logic signed [ERR_W-1:0] i_error_sample = '0;
    logic                    i_restart = 1'b0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic signed [ERR_W-1:0] o_drive;
    logic                    o_drive_clipped;
    logic                    o_sum_clipped;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [GAIN_W-1:0]       i_cfg_data = '0;

    // pending sample words and the drive words they must produce
    t_err_word err_word_q[$];
    t_result   drive_q[$];

    // predictor copy of the gains and the controller history
    longint kp = 0;
    longint ki = 0;
    longint kd = 0;
    longint prev_err = 0;
    longint integ_acc = 0;

    // idling knobs, percent of cycles
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // long receiver hold-off requests
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;

    int cycle_cnt = 0;
    int err_cnt = 0;
    int words_sent = 0;
    int results_seen = 0;
    int drive_clips = 0;
    int sum_clips = 0;
    int full_stalls = 0;
    int cfg_writes = 0;

    pid_controller dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_error_sample  (i_error_sample),
        .i_restart       (i_restart),
        .empty           (empty),
        .pop             (pop),
        .o_drive         (o_drive),
        .o_drive_clipped (o_drive_clipped),
        .o_sum_clipped   (o_sum_clipped),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // one pid step: update history, then round and clip the negated weighted sum
    task automatic pid_predict(input t_err_word w, output t_result r);
        longint e;
        longint d;
        longint s;
        longint acc;
        e = $signed(w.error_sample);
        r.sum_clipped = 1'b0;
        r.drive_clipped = 1'b0;
        // restart wipes the history before this sample is used
        if (w.restart) begin
            prev_err = 0;
            integ_acc = 0;
        end
        d = e - prev_err;
        s = integ_acc + e;
        if (s > longint'(SUM_MAX)) begin
            s = longint'(SUM_MAX);
            r.sum_clipped = 1'b1;
        end else if (s < longint'(SUM_MIN)) begin
            s = longint'(SUM_MIN);
            r.sum_clipped = 1'b1;
        end
        integ_acc = s;
        prev_err = e;
        // products stay well inside 64 bits at these widths
        acc = -(kp * e + kd * d + ki * s) + ROUND_HALF;
        acc = acc >>> GAIN_FRAC;
        if (acc > longint'(DRIVE_MAX)) begin
            acc = longint'(DRIVE_MAX);
            r.drive_clipped = 1'b1;
        end else if (acc < longint'(DRIVE_MIN)) begin
            acc = longint'(DRIVE_MIN);
            r.drive_clipped = 1'b1;
        end
        r.drive = acc[ERR_W-1:0];
    endtask

    // driver: offers the oldest pending word, holds it until the block takes it
    always @(posedge i_clk) begin : sample_driver
        t_result predicted;
        logic    holding;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && full) begin
                full_stalls++;
            end
            if (push && !full) begin
                pid_predict(err_word_q.pop_front(), predicted);
                drive_q.push_back(predicted);
                words_sent++;
                holding = 1'b0;
            end else begin
                holding = push;
            end
            // a word in flight stays on the ports, otherwise maybe start the next one
            if (!holding) begin
                if (err_word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    push <= 1'b1;
                    i_error_sample <= err_word_q[0].error_sample;
                    i_restart <= err_word_q[0].restart;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off counter, loaded once per request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            hold_left <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
    end

    // monitor: checks every popped result word against the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                results_seen++;
                if (drive_q.size() == 0) begin
                    $display("%0t: result word with nothing expected, got drive %0d",
                             $time, o_drive);
                    err_cnt++;
                end else begin
                    want = drive_q.pop_front();
                    if (want.drive_clipped) drive_clips++;
                    if (want.sum_clipped) sum_clips++;
                    if (o_drive !== want.drive) begin
                        $display("%0t: drive mismatch, expected %0d, got %0d",
                                 $time, $signed(want.drive), o_drive);
                        err_cnt++;
                    end
                    if (o_drive_clipped !== want.drive_clipped) begin
                        $display("%0t: drive_clipped mismatch, expected %0b, got %0b",
                                 $time, want.drive_clipped, o_drive_clipped);
                        err_cnt++;
                    end
                    if (o_sum_clipped !== want.sum_clipped) begin
                        $display("%0t: sum_clipped mismatch, expected %0b, got %0b",
                                 $time, want.sum_clipped, o_sum_clipped);
                        err_cnt++;
                    end
                end
            end
            pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_cnt, drive_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one gain register write, only issued while the block is idle
    task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_PROP_GAIN:  kp = $signed(val);
            CFG_INTEG_GAIN: ki = $signed(val);
            CFG_DERIV_GAIN: kd = $signed(val);
            default: ;
        endcase
    endtask

    task automatic load_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                              input logic [GAIN_W-1:0] d);
        write_gain(CFG_PROP_GAIN, p);
        write_gain(CFG_INTEG_GAIN, i);
        write_gain(CFG_DERIV_GAIN, d);
        @(negedge i_clk);
    endtask

    // wait for the sender queue, the port and the expected results to run dry
    task automatic wait_drained();
        do @(negedge i_clk); while (err_word_q.size() != 0 || push || drive_q.size() != 0);
        repeat (LAT_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_word(input logic signed [ERR_W-1:0] e, input logic r);
        t_err_word w;
        w.error_sample = e;
        w.restart = r;
        err_word_q.push_back(w);
    endtask

    // either any 24-bit pattern or a gain within about two
    function automatic logic [GAIN_W-1:0] rand_gain();
        if ($urandom_range(2) == 0) return GAIN_W'($urandom());
        return GAIN_W'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
    endfunction

    function automatic t_err_word rand_word();
        t_err_word w;
        int        pick;
        pick = $urandom_range(15);
        case (pick)
            0:       w.error_sample = ERR_MAX;
            1:       w.error_sample = ERR_MIN;
            2:       w.error_sample = '0;
            3, 4, 5: w.error_sample = ERR_W'(int'($urandom_range(0, 1024)) - 512);
            default: w.error_sample = ERR_W'($urandom());
        endcase
        w.restart = ($urandom_range(15) == 0);
        return w;
    endfunction

    // fresh random gains, then a batch of random words under the given idling
    task automatic random_phase(input int n, input int send_pct, input int recv_pct);
        load_gains(rand_gain(), rand_gain(), rand_gain());
        if ($urandom_range(1) == 0) begin
            write_gain(CFG_UNUSED, GAIN_W'($urandom()));
            @(negedge i_clk);
        end
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n) err_word_q.push_back(rand_word());
        wait_drained();
    endtask

    initial begin : stimulus
        int guard;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // gains still at reset, drive must be zero
        queue_word(16'sh1234, 1'b0);
        queue_word(ERR_MIN, 1'b0);
        wait_drained();

        // unit proportional gain: drive is the negated sample, most negative one clips
        load_gains(GAIN_ONE, '0, '0);
        queue_word(ERR_MAX, 1'b0);
        queue_word(ERR_MIN, 1'b0);
        queue_word(16'sd0, 1'b0);
        queue_word(16'sd1, 1'b1);
        wait_drained();

        // half gain: ties round toward plus infinity
        load_gains(GAIN_HALF, '0, '0);
        queue_word(16'sd1, 1'b0);
        queue_word(-16'sd1, 1'b0);
        queue_word(16'sd3, 1'b0);
        queue_word(-16'sd3, 1'b0);
        wait_drained();

        // derivative only, restart makes the derivative equal the sample
        load_gains('0, '0, GAIN_ONE);
        queue_word(16'sd100, 1'b0);
        queue_word(16'sd200, 1'b0);
        queue_word(16'sd50, 1'b1);
        wait_drained();

        // integral only, running sum then restart
        load_gains('0, GAIN_ONE, '0);
        queue_word(16'sd1000, 1'b0);
        queue_word(16'sd1000, 1'b0);
        queue_word(16'sd1000, 1'b0);
        queue_word(-16'sd7, 1'b1);
        wait_drained();

        // extreme gains, plus a write to the unused index that must change nothing
        load_gains(GAIN_MAX, GAIN_MIN, GAIN_MAX);
        write_gain(CFG_UNUSED, GAIN_MAX);
        @(negedge i_clk);
        queue_word(ERR_MAX, 1'b1);
        queue_word(ERR_MIN, 1'b0);
        queue_word(16'sd0, 1'b0);
        queue_word(ERR_MAX, 1'b0);
        queue_word(16'sd1, 1'b1);
        queue_word(ERR_MIN, 1'b1);
        wait_drained();

        // long one-sided runs grow the integral both ways, small gain keeps drive in range
        load_gains('0, GAIN_W'(16), '0);
        queue_word(ERR_MAX, 1'b1);
        repeat (SAT_WORDS) queue_word(ERR_MAX - ERR_W'($urandom_range(15)), 1'b0);
        queue_word(ERR_MIN, 1'b1);
        repeat (SAT_WORDS) queue_word(ERR_MIN + ERR_W'($urandom_range(15)), 1'b0);
        wait_drained();

        // random words over the idling mixes
        random_phase(200, 0, 0);
        random_phase(200, 88, 0);
        random_phase(200, 0, 88);
        random_phase(200, 6, 6);

        // receiver holds off while the sender keeps pushing, so the block backs up
        load_gains(rand_gain(), rand_gain(), rand_gain());
        send_idle_pct = 0;
        recv_stall_pct = 0;
        holds_asked++;
        repeat (120) err_word_q.push_back(rand_word());
        wait_drained();
        // sender waits for every result before the next burst
        repeat (40) err_word_q.push_back(rand_word());
        wait_drained();

        // most negative gains to close
        load_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN);
        send_idle_pct = 6;
        recv_stall_pct = 6;
        repeat (150) err_word_q.push_back(rand_word());

        // final drain with its own bound, then let any stray word show up
        guard = 0;
        while ((err_word_q.size() != 0 || push || drive_q.size() != 0) && guard < DRAIN_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        if (drive_q.size() != 0) begin
            $display("%0t: %0d expected words never came out", $time, drive_q.size());
            err_cnt++;
        end
        repeat (LAT_CYCLES) @(negedge i_clk);

        $display("covered %0d sample words, %0d results, %0d drive clips, %0d integral clips",
                 words_sent, results_seen, drive_clips, sum_clips);
        $display("%0d gain writes, input blocked on full for %0d cycles, %0d mismatches",
                 cfg_writes, full_stalls, err_cnt);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/pid_pkg.sv
rtl/core/pid_front.sv
rtl/core/pid_back.sv
rtl/core/pid_controller.sv
verif/pid_controller_tb.sv
